/* rtl/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// Pair force field sampler package
// Shared constants, command and register codes, and the atom and pair result
// types.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int MUL_LAT     = 3;
  localparam int DIV_STAGES  = 64;
  localparam int SQRT_STAGES = 32;

  // Latency of the pair force unit from atom input to registered result.
  localparam int PAIR_LAT = 3 + DIV_STAGES + 3 + SQRT_STAGES + 1 + 3 * MUL_LAT + 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic REG_FORCE_KIND = 1'b0;
  localparam logic REG_ATOM_COUNT = 1'b1;

  localparam logic [1:0] KIND_LJ   = 2'd0;
  localparam logic [1:0] KIND_COUL = 2'd1;

  localparam logic [63:0] LIM_U64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCAL_LIM  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FORCE_LIM = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] six;
    logic [31:0] twelve;
    logic [31:0] charge;
  } atom_t;

  typedef struct packed {
    logic            sat;
    logic [2:0][47:0] lj_f;
    logic [2:0][47:0] c_f;
  } pair_res_t;

endpackage

/* rtl/pfs_delay.sv */
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries a payload word through a fixed number of register stages.
// ----------------------------------------------------------------------------
module pfs_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < D; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[D-1];

endmodule

/* rtl/pfs_mulsh.sv */
// ----------------------------------------------------------------------------
// Scaled multiplier
// Unsigned 64 by 64 product, shifted right and clamped, over three stages.
// ----------------------------------------------------------------------------
module pfs_mulsh #(
  parameter int          SH  = 48,
  parameter logic [63:0] LIM = 64'hFFFF_FFFF_FFFF_FFFF
) (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        sat
);

  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic [127:0] prod;
  logic [63:0]  r;
  logic         over;

  always_ff @(posedge clk) begin
    p00 <= a[31:0] * b[31:0];
    p01 <= a[31:0] * b[63:32];
    p10 <= a[63:32] * b[31:0];
    p11 <= a[63:32] * b[63:32];
  end

  always_ff @(posedge clk) begin
    prod <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
  end

  assign over = |prod[127:64+SH];
  assign r    = prod[SH+63:SH];

  always_ff @(posedge clk) begin
    sat <= over || (r > LIM);
    p   <= (over || (r > LIM)) ? LIM : r;
  end

endmodule

/* rtl/pfs_recip.sv */
// ----------------------------------------------------------------------------
// Pipelined reciprocal
// Restoring division of all ones by the squared distance, one quotient bit a
// stage.
// ----------------------------------------------------------------------------
module pfs_recip (
  input  logic        clk,
  input  logic [49:0] den,
  output logic [63:0] quo
);

  logic [49:0] rem [pfs_pkg::DIV_STAGES];
  logic [49:0] dv  [pfs_pkg::DIV_STAGES];
  logic [63:0] q   [pfs_pkg::DIV_STAGES];

  for (genvar i = 0; i < pfs_pkg::DIV_STAGES; i++) begin : g_st
    logic [49:0] rem_in;
    logic [49:0] dv_in;
    logic [63:0] q_in;
    logic [50:0] t;

    if (i == 0) begin : g_in
      assign rem_in = '0;
      assign dv_in  = den;
      assign q_in   = '0;
    end else begin : g_in
      assign rem_in = rem[i-1];
      assign dv_in  = dv[i-1];
      assign q_in   = q[i-1];
    end

    assign t = {rem_in, 1'b1};

    always_ff @(posedge clk) begin
      dv[i] <= dv_in;
      if (t >= {1'b0, dv_in}) begin
        rem[i] <= 50'(t - {1'b0, dv_in});
        q[i]   <= {q_in[62:0], 1'b1};
      end else begin
        rem[i] <= t[49:0];
        q[i]   <= {q_in[62:0], 1'b0};
      end
    end
  end

  assign quo = q[pfs_pkg::DIV_STAGES-1];

endmodule

/* rtl/pfs_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit square root of a 64-bit word, one result bit a stage.
// ----------------------------------------------------------------------------
module pfs_isqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] v   [pfs_pkg::SQRT_STAGES];
  logic [63:0] res [pfs_pkg::SQRT_STAGES];

  for (genvar j = 0; j < pfs_pkg::SQRT_STAGES; j++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] v_in;
    logic [63:0] res_in;
    logic [63:0] trial;

    if (j == 0) begin : g_in
      assign v_in   = rad;
      assign res_in = '0;
    end else begin : g_in
      assign v_in   = v[j-1];
      assign res_in = res[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (v_in >= trial) begin
        v[j]   <= v_in - trial;
        res[j] <= (res_in >> 1) + BIT;
      end else begin
        v[j]   <= v_in;
        res[j] <= res_in >> 1;
      end
    end
  end

  assign root = res[pfs_pkg::SQRT_STAGES-1][31:0];

endmodule

/* rtl/pfs_pair.sv */
// ----------------------------------------------------------------------------
// Pair force unit
// Lennard-Jones and Coulomb force of one atom on the probe, one atom a cycle.
// ----------------------------------------------------------------------------
module pfs_pair (
  input  logic               clk,
  input  pfs_pkg::atom_t     atom,
  input  logic [31:0]        probe_x,
  input  logic [31:0]        probe_y,
  input  logic [31:0]        probe_z,
  input  logic               do_lj,
  input  logic               do_c,
  output pfs_pkg::pair_res_t res
);

  localparam int MUL  = pfs_pkg::MUL_LAT;
  localparam int SQ   = pfs_pkg::SQRT_STAGES;
  localparam int T0   = 3 + pfs_pkg::DIV_STAGES;
  localparam int TL   = T0 + 4 * MUL + 1;
  localparam int TC   = T0 + 3 + SQ + 1 + 2 * MUL + 1;

  function automatic logic [31:0] umag32(input logic [31:0] c);
    return c[31] ? (32'd0 - c) : c;
  endfunction

  function automatic logic [63:0] umag64(input logic [63:0] s);
    return s[63] ? (64'd0 - s) : s;
  endfunction

  logic [2:0][31:0] apos;
  logic [2:0][31:0] ppos;
  logic [2:0][32:0] dd;
  logic [2:0][31:0] dmag1;
  logic [2:0]       dneg1;
  logic [35:0]      six_k1;
  logic [35:0]      twelve_k1;
  logic [31:0]      kqq1;
  logic             six_neg1;
  logic             twelve_neg1;
  logic             kqq_neg1;
  logic [2:0][63:0] sq2;
  logic [49:0]      rsq3;
  logic             r0_3;

  assign apos = {atom.z, atom.y, atom.x};
  assign ppos = {probe_z, probe_y, probe_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a] = {apos[a][31], apos[a]} - {ppos[a][31], ppos[a]};
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      dneg1[a] <= dd[a][32];
      dmag1[a] <= dd[a][32] ? 32'(33'd0 - dd[a]) : dd[a][31:0];
    end
    six_k1      <= 36'(umag32(atom.six)) * 36'd6;
    twelve_k1   <= 36'(umag32(atom.twelve)) * 36'd12;
    kqq1        <= umag32(atom.charge);
    six_neg1    <= atom.six[31];
    twelve_neg1 <= atom.twelve[31];
    kqq_neg1    <= atom.charge[31];
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq2[a] <= dmag1[a] * dmag1[a];
    end
  end

  always_ff @(posedge clk) begin
    rsq3 <= 50'(sq2[0][63:16]) + 50'(sq2[1][63:16]) + 50'(sq2[2][63:16]);
    r0_3 <= (sq2[0][63:16] == '0) && (sq2[1][63:16] == '0) && (sq2[2][63:16] == '0);
  end

  logic [63:0] ir2;

  pfs_recip u_recip (.clk(clk), .den(rsq3), .quo(ir2));

  // Lennard-Jones branch.
  logic [63:0] ir4, ir6, ir8, ir14, ir2_d3, ir8_d3;
  logic        s4, s6, s8, s14, s4_d3;
  logic        f6, f6_d3, f9, f9_d3;
  logic [63:0] p6, p12;
  logic        sp6, sp12;
  logic [35:0] six_k9, twelve_k9;
  logic        six_neg12, twelve_neg12;
  logic [63:0] s_lj;
  logic        flj;
  logic [63:0] s_lj_a;
  logic        flj_a;

  pfs_mulsh #(.SH(48), .LIM(pfs_pkg::LIM_U64)) u_m4 (
    .clk(clk), .a(ir2), .b(ir2), .p(ir4), .sat(s4));
  pfs_delay #(.W(65), .D(MUL)) u_d_ir2a (
    .clk(clk), .din({s4, ir2}), .dout({s4_d3, ir2_d3}));
  pfs_mulsh #(.SH(48), .LIM(pfs_pkg::LIM_U64)) u_m6 (
    .clk(clk), .a(ir4), .b(ir2_d3), .p(ir6), .sat(s6));
  pfs_mulsh #(.SH(48), .LIM(pfs_pkg::LIM_U64)) u_m8 (
    .clk(clk), .a(ir4), .b(ir4), .p(ir8), .sat(s8));

  assign f6 = s4_d3 | s6 | s8;

  pfs_delay #(.W(65), .D(MUL)) u_d_ir8 (
    .clk(clk), .din({f6, ir8}), .dout({f6_d3, ir8_d3}));
  pfs_mulsh #(.SH(48), .LIM(pfs_pkg::LIM_U64)) u_m14 (
    .clk(clk), .a(ir8), .b(ir6), .p(ir14), .sat(s14));

  assign f9 = f6_d3 | s14;

  pfs_delay #(.W(1), .D(MUL)) u_d_f9 (.clk(clk), .din(f9), .dout(f9_d3));
  pfs_delay #(.W(72), .D(T0 + 3 * MUL - 1)) u_d_ljk (
    .clk(clk), .din({six_k1, twelve_k1}), .dout({six_k9, twelve_k9}));
  pfs_delay #(.W(2), .D(T0 + 4 * MUL - 1)) u_d_ljs (
    .clk(clk), .din({six_neg1, twelve_neg1}), .dout({six_neg12, twelve_neg12}));

  pfs_mulsh #(.SH(16), .LIM(pfs_pkg::SCAL_LIM)) u_mp6 (
    .clk(clk), .a({28'd0, six_k9}), .b(ir8_d3), .p(p6), .sat(sp6));
  pfs_mulsh #(.SH(16), .LIM(pfs_pkg::SCAL_LIM)) u_mp12 (
    .clk(clk), .a({28'd0, twelve_k9}), .b(ir14), .p(p12), .sat(sp12));

  always_ff @(posedge clk) begin
    s_lj <= (six_neg12 ? (64'd0 - p6) : p6) - (twelve_neg12 ? (64'd0 - p12) : p12);
    flj  <= f9_d3 | sp6 | sp12;
  end

  pfs_delay #(.W(65), .D(TC - TL)) u_d_lj (
    .clk(clk), .din({flj, s_lj}), .dout({flj_a, s_lj_a}));

  // Coulomb branch.
  logic [23:0] okf;
  logic [63:0] ir2_c1, ir2_c2, rad;
  logic [5:0]  sh, sh_d;
  logic [31:0] root;
  logic [63:0] ir, ir2_d, ir3, pc;
  logic        s3, s3_d3, spc;
  logic [31:0] kqq_d;
  logic        kqq_neg_d;
  logic [63:0] s_c;
  logic        fc;

  always_ff @(posedge clk) begin
    for (int k = 1; k <= 24; k++) begin
      okf[k-1] <= (ir2 >> (64 - 2 * k)) == 64'd0;
    end
    ir2_c1 <= ir2;
    sh     <= 6'($countones(okf) * 2);
    ir2_c2 <= ir2_c1;
    rad    <= ir2_c2 << sh;
  end

  pfs_isqrt u_isqrt (.clk(clk), .rad(rad), .root(root));
  pfs_delay #(.W(6), .D(SQ + 1)) u_d_sh (.clk(clk), .din(sh), .dout(sh_d));

  always_ff @(posedge clk) begin
    ir <= {32'd0, root} << ((6'd48 - sh_d) >> 1);
  end

  pfs_delay #(.W(64), .D(3 + SQ + 1)) u_d_ir2c (.clk(clk), .din(ir2), .dout(ir2_d));
  pfs_mulsh #(.SH(48), .LIM(pfs_pkg::LIM_U64)) u_m3 (
    .clk(clk), .a(ir2_d), .b(ir), .p(ir3), .sat(s3));
  pfs_delay #(.W(1), .D(MUL)) u_d_s3 (.clk(clk), .din(s3), .dout(s3_d3));
  pfs_delay #(.W(32), .D(T0 + 3 + SQ + 1 + MUL - 1)) u_d_kqq (
    .clk(clk), .din(kqq1), .dout(kqq_d));
  pfs_delay #(.W(1), .D(TC - 2)) u_d_kqn (.clk(clk), .din(kqq_neg1), .dout(kqq_neg_d));
  pfs_mulsh #(.SH(16), .LIM(pfs_pkg::SCAL_LIM)) u_mpc (
    .clk(clk), .a({32'd0, kqq_d}), .b(ir3), .p(pc), .sat(spc));

  always_ff @(posedge clk) begin
    s_c <= kqq_neg_d ? (64'd0 - pc) : pc;
    fc  <= s3_d3 | spc;
  end

  // Force per axis.
  logic [2:0][31:0] dmag_d;
  logic [2:0]       dneg_d;
  logic             r0_d;
  logic             lj_neg_d, c_neg_d, flj_d, fc_d;
  logic [2:0][63:0] flj_m, fc_m;
  logic [2:0]       flj_s, fc_s;
  logic [2:0][47:0] lj_v, c_v;

  pfs_delay #(.W(96), .D(TC - 1)) u_d_dm (.clk(clk), .din(dmag1), .dout(dmag_d));
  pfs_delay #(.W(3), .D(TC + MUL - 1)) u_d_dn (.clk(clk), .din(dneg1), .dout(dneg_d));
  pfs_delay #(.W(1), .D(TC + MUL - 3)) u_d_r0 (.clk(clk), .din(r0_3), .dout(r0_d));
  pfs_delay #(.W(4), .D(MUL)) u_d_fs (
    .clk(clk), .din({s_lj_a[63], s_c[63], flj_a, fc}),
    .dout({lj_neg_d, c_neg_d, flj_d, fc_d}));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pfs_mulsh #(.SH(40), .LIM(pfs_pkg::FORCE_LIM)) u_flj (
      .clk(clk), .a(umag64(s_lj_a)), .b({32'd0, dmag_d[a]}), .p(flj_m[a]), .sat(flj_s[a]));
    pfs_mulsh #(.SH(40), .LIM(pfs_pkg::FORCE_LIM)) u_fc (
      .clk(clk), .a(umag64(s_c)), .b({32'd0, dmag_d[a]}), .p(fc_m[a]), .sat(fc_s[a]));

    assign lj_v[a] = (lj_neg_d ^ dneg_d[a]) ? (48'd0 - flj_m[a][47:0]) : flj_m[a][47:0];
    assign c_v[a]  = (c_neg_d ^ dneg_d[a]) ? (48'd0 - fc_m[a][47:0]) : fc_m[a][47:0];
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      res.lj_f[a] <= (do_lj && !r0_d) ? lj_v[a] : 48'd0;
      res.c_f[a]  <= (do_c && !r0_d) ? c_v[a] : 48'd0;
    end
    res.sat <= r0_d || (do_lj && (flj_d || (|flj_s))) || (do_c && (fc_d || (|fc_s)));
  end

endmodule

/* rtl/pair_force_field_sampler.sv */
// ----------------------------------------------------------------------------
// Pair force field sampler
// Atom table and force accumulator around a pipelined pair force unit.
// ----------------------------------------------------------------------------
// A load item writes one atom into the table. An evaluate item streams the
// first N atoms (N is atom_count limited to MAX_ATOMS) from the atom table,
// which has one write and one read port, through the pair force unit at one
// atom per cycle; its result is offered once the last atom's result has been
// accumulated. When N is zero no atom is streamed and the base force is
// offered. While an evaluation runs no input is taken, but a finished result
// may wait in the output register while the next items are taken. Forces are
// Q24.24; the saturated flag is raised by any clamp or coincident atom during
// the evaluation.
// ----------------------------------------------------------------------------
module pair_force_field_sampler #(
  parameter int MAX_ATOMS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [7:0]         atom_slot,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] coef_six,
  input  logic signed [31:0] coef_twelve,
  input  logic signed [31:0] charge_const,
  input  logic signed [47:0] base_fx,
  input  logic signed [47:0] base_fy,
  input  logic signed [47:0] base_fz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic               saturated
);

  localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW    = $clog2(MAX_ATOMS + 1);
  localparam int ACC_W = 49 + CW;
  localparam int LAT   = pfs_pkg::PAIR_LAT;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  function automatic logic [48:0] clamp48(input logic [ACC_W-1:0] v);
    logic over;
    logic under;
    over  = !v[ACC_W-1] && (|v[ACC_W-2:47]);
    under = v[ACC_W-1] && !(&v[ACC_W-2:47]);
    if (over) begin
      return {1'b1, 48'h7FFF_FFFF_FFFF};
    end else if (under) begin
      return {1'b1, 48'h8000_0000_0000};
    end
    return {1'b0, v[47:0]};
  endfunction

  logic [1:0]         state;
  logic [1:0]         force_kind;
  logic [8:0]         atom_count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      n_lim;
  logic [CW-1:0]      n_new;
  logic [LAT:0]       tag_v;
  logic [LAT:0]       tag_l;
  logic               accept;
  logic               issue;
  logic               last_issue;
  logic [31:0]        probe_x;
  logic [31:0]        probe_y;
  logic [31:0]        probe_z;
  pfs_pkg::atom_t     mem [MAX_ATOMS];
  pfs_pkg::atom_t     rd_atom;
  pfs_pkg::pair_res_t pres;
  logic [2:0][ACC_W-1:0] acc;
  logic               sat_acc;
  logic [48:0]        cx;
  logic [48:0]        cy;
  logic [48:0]        cz;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign issue      = (state == ST_RUN);
  assign last_issue = issue && (idx == n_lim - 1'b1);
  assign n_new      = (32'(atom_count) > 32'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(atom_count);

  always_ff @(posedge clk) begin
    if (accept && cmd == pfs_pkg::CMD_LOAD && 32'(atom_slot) < 32'(MAX_ATOMS)) begin
      mem[AW'(atom_slot)] <= '{x: pos_x, y: pos_y, z: pos_z, six: coef_six,
                               twelve: coef_twelve, charge: charge_const};
    end
    rd_atom <= mem[idx[AW-1:0]];
  end

  pfs_pair u_pair (
    .clk     (clk),
    .atom    (rd_atom),
    .probe_x (probe_x),
    .probe_y (probe_y),
    .probe_z (probe_z),
    .do_lj   (force_kind != pfs_pkg::KIND_COUL),
    .do_c    (force_kind != pfs_pkg::KIND_LJ),
    .res     (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      force_kind <= '0;
      atom_count <= '0;
      idx        <= '0;
      n_lim      <= '0;
      tag_v      <= '0;
      tag_l      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == pfs_pkg::REG_FORCE_KIND) begin
          force_kind <= cfg_data[1:0];
        end else begin
          atom_count <= cfg_data;
        end
      end
      tag_v <= {tag_v[LAT-1:0], issue};
      tag_l <= {tag_l[LAT-1:0], last_issue};
      if (state == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && cmd == pfs_pkg::CMD_EVAL) begin
            idx   <= '0;
            n_lim <= n_new;
            state <= (n_new == '0) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          idx <= idx + 1'b1;
          if (last_issue) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tag_v[LAT] && tag_l[LAT]) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cx = clamp48(acc[0]);
  assign cy = clamp48(acc[1]);
  assign cz = clamp48(acc[2]);

  always_ff @(posedge clk) begin
    if (accept && cmd == pfs_pkg::CMD_EVAL) begin
      probe_x <= pos_x;
      probe_y <= pos_y;
      probe_z <= pos_z;
      acc[0]  <= {{(ACC_W-48){base_fx[47]}}, base_fx};
      acc[1]  <= {{(ACC_W-48){base_fy[47]}}, base_fy};
      acc[2]  <= {{(ACC_W-48){base_fz[47]}}, base_fz};
      sat_acc <= 1'b0;
    end else if (tag_v[LAT]) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] <= acc[a] + {{(ACC_W-48){pres.lj_f[a][47]}}, pres.lj_f[a]}
                         + {{(ACC_W-48){pres.c_f[a][47]}}, pres.c_f[a]};
      end
      sat_acc <= sat_acc | pres.sat;
    end
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      force_x   <= cx[47:0];
      force_y   <= cy[47:0];
      force_z   <= cz[47:0];
      saturated <= sat_acc | cx[48] | cy[48] | cz[48];
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> tag_v == '0)
    else $error("atom results still in flight while idle");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> idx < n_lim)
    else $error("atom index beyond the evaluation count");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("finished evaluation did not reach the output register");
`endif

endmodule
